@@ hw/rtl/gqa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gqa_pkg
// Shared types, constants and tables for the gyro quaternion attitude block.
// ----------------------------------------------------------------------------
package gqa_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int SQRT_STEPS   = 32;
  localparam int DIV_STEPS    = 31;

  localparam logic [23:0]        TIME_STEP_RESET = 24'd167772;
  localparam logic signed [31:0] ONE_Q30         = 32'sh4000_0000;
  localparam logic signed [31:0] PI_Q28          = 32'sd843314857;
  localparam logic signed [31:0] HALF_PI_Q28     = 32'sd421657428;
  localparam logic               REG_TIME_STEP   = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RATE,
    ST_EULER,
    ST_SQUARE,
    ST_MAG,
    ST_DIV,
    ST_PITCH,
    ST_PSQRT,
    ST_CINIT,
    ST_CORDIC,
    ST_ROLL,
    ST_OUT
  } state_e;

  typedef enum logic {
    OP_SQRT,
    OP_DIV
  } unit_op_e;

  typedef struct packed {
    logic     start;
    unit_op_e op;
  } unit_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } unit_rsp_t;

  // one term of the rate product: attitude index, rate index, sign, slot, component
  typedef struct packed {
    logic [1:0] qi;
    logic [1:0] ri;
    logic       neg;
    logic [1:0] pos;
    logic [1:0] comp;
  } term_t;

  function automatic term_t rate_term(input logic [3:0] t);
    term_t r;
    r = '0;
    case (t)
      4'd0:  r = '{qi: 2'd1, ri: 2'd0, neg: 1'b1, pos: 2'd0, comp: 2'd0};
      4'd1:  r = '{qi: 2'd2, ri: 2'd1, neg: 1'b1, pos: 2'd1, comp: 2'd0};
      4'd2:  r = '{qi: 2'd3, ri: 2'd2, neg: 1'b1, pos: 2'd2, comp: 2'd0};
      4'd3:  r = '{qi: 2'd0, ri: 2'd0, neg: 1'b0, pos: 2'd0, comp: 2'd1};
      4'd4:  r = '{qi: 2'd2, ri: 2'd2, neg: 1'b0, pos: 2'd1, comp: 2'd1};
      4'd5:  r = '{qi: 2'd3, ri: 2'd1, neg: 1'b1, pos: 2'd2, comp: 2'd1};
      4'd6:  r = '{qi: 2'd0, ri: 2'd1, neg: 1'b0, pos: 2'd0, comp: 2'd2};
      4'd7:  r = '{qi: 2'd1, ri: 2'd2, neg: 1'b1, pos: 2'd1, comp: 2'd2};
      4'd8:  r = '{qi: 2'd3, ri: 2'd0, neg: 1'b0, pos: 2'd2, comp: 2'd2};
      4'd9:  r = '{qi: 2'd0, ri: 2'd2, neg: 1'b0, pos: 2'd0, comp: 2'd3};
      4'd10: r = '{qi: 2'd1, ri: 2'd1, neg: 1'b0, pos: 2'd1, comp: 2'd3};
      4'd11: r = '{qi: 2'd2, ri: 2'd0, neg: 1'b1, pos: 2'd2, comp: 2'd3};
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] atan_entry(input logic [4:0] i);
    logic signed [31:0] r;
    r = '0;
    case (i)
      5'd0:  r = 32'sd210828714;
      5'd1:  r = 32'sd124459457;
      5'd2:  r = 32'sd65760959;
      5'd3:  r = 32'sd33381290;
      5'd4:  r = 32'sd16755422;
      5'd5:  r = 32'sd8385879;
      5'd6:  r = 32'sd4193963;
      5'd7:  r = 32'sd2097109;
      5'd8:  r = 32'sd1048571;
      5'd9:  r = 32'sd524287;
      5'd10: r = 32'sd262144;
      5'd11: r = 32'sd131072;
      5'd12: r = 32'sd65536;
      5'd13: r = 32'sd32768;
      5'd14: r = 32'sd16384;
      5'd15: r = 32'sd8192;
      5'd16: r = 32'sd4096;
      5'd17: r = 32'sd2048;
      5'd18: r = 32'sd1024;
      5'd19: r = 32'sd512;
      5'd20: r = 32'sd256;
      5'd21: r = 32'sd128;
      5'd22: r = 32'sd64;
      5'd23: r = 32'sd32;
      5'd24: r = 32'sd16;
      5'd25: r = 32'sd8;
      5'd26: r = 32'sd4;
      5'd27: r = 32'sd2;
      5'd28: r = 32'sd1;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [63:0] v);
    logic signed [39:0] r;
    if (v > 64'sh0000_007F_FFFF_FFFF) begin
      r = 40'sh7F_FFFF_FFFF;
    end else if (v < -64'sh0000_0080_0000_0000) begin
      r = -40'sh80_0000_0000;
    end else begin
      r = 40'(v);
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
    logic signed [31:0] r;
    if (v > 41'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -41'sh0_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/gqa_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gqa_in_if
// Gyro sample channel: one word holds three body rates.
// ----------------------------------------------------------------------------
interface gqa_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] rate_x;
  logic signed [31:0] rate_y;
  logic signed [31:0] rate_z;

  modport source (output valid, output rate_x, output rate_y, output rate_z, input ready);
  modport sink   (input valid, input rate_x, input rate_y, input rate_z, output ready);
endinterface

@@ hw/rtl/gqa_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gqa_out_if
// Attitude channel: quaternion plus pitch and roll per word.
// ----------------------------------------------------------------------------
interface gqa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] att_w;
  logic signed [31:0] att_x;
  logic signed [31:0] att_y;
  logic signed [31:0] att_z;
  logic signed [30:0] pitch_angle;
  logic signed [30:0] roll_angle;

  modport source (output valid, output att_w, output att_x, output att_y, output att_z,
                  output pitch_angle, output roll_angle, input ready);
  modport sink   (input valid, input att_w, input att_x, input att_y, input att_z,
                  input pitch_angle, input roll_angle, output ready);
endinterface

@@ hw/rtl/gqa_root_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gqa_root_div
// Bit-serial unit: 64-bit integer square root or clamped Q1.30 divide.
// ----------------------------------------------------------------------------
module gqa_root_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gqa_pkg::unit_req_t  req_i,
  input  logic [63:0]         opa_i,
  input  logic [31:0]         opb_i,
  output gqa_pkg::unit_rsp_t  rsp_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  gqa_pkg::unit_op_e op_q, op_d;
  logic [4:0]        cnt_q, cnt_d;
  logic [63:0]       v_q, v_d;
  logic [63:0]       res_q, res_d;
  logic [63:0]       bit_q, bit_d;
  logic [33:0]       rem_q, rem_d;
  logic [31:0]       den_q, den_d;
  logic [30:0]       num_q, num_d;
  logic [30:0]       quo_q, quo_d;
  logic [31:0]       result_q, result_d;
  logic [63:0]       trial;
  logic [63:0]       res_n;
  logic [33:0]       r2;
  logic [30:0]       quo_n;

  always_comb begin
    busy_d   = busy_q;
    done_d   = 1'b0;
    op_d     = op_q;
    cnt_d    = cnt_q;
    v_d      = v_q;
    res_d    = res_q;
    bit_d    = bit_q;
    rem_d    = rem_q;
    den_d    = den_q;
    num_d    = num_q;
    quo_d    = quo_q;
    result_d = result_q;
    trial    = res_q + bit_q;
    res_n    = '0;
    r2       = {rem_q[32:0], num_q[30]};
    quo_n    = '0;
    if (!busy_q) begin
      if (req_i.start) begin
        op_d  = req_i.op;
        cnt_d = '0;
        if (req_i.op == gqa_pkg::OP_SQRT) begin
          v_d    = opa_i;
          res_d  = '0;
          bit_d  = 64'd1 << 62;
          busy_d = 1'b1;
        end else if (opa_i[62:0] >= {opb_i, 31'b0}) begin
          result_d = 32'(gqa_pkg::ONE_Q30);
          done_d   = 1'b1;
        end else begin
          rem_d  = {4'b0, opa_i[60:31]};
          num_d  = opa_i[30:0];
          den_d  = opb_i;
          quo_d  = '0;
          busy_d = 1'b1;
        end
      end
    end else if (op_q == gqa_pkg::OP_SQRT) begin
      if (v_q >= trial) begin
        v_d   = v_q - trial;
        res_n = (res_q >> 1) + bit_q;
      end else begin
        res_n = res_q >> 1;
      end
      res_d = res_n;
      bit_d = bit_q >> 2;
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'(gqa_pkg::SQRT_STEPS - 1)) begin
        result_d = res_n[31:0];
        done_d   = 1'b1;
        busy_d   = 1'b0;
      end
    end else begin
      num_d = {num_q[29:0], 1'b0};
      if (r2 >= {2'b0, den_q}) begin
        rem_d = r2 - {2'b0, den_q};
        quo_n = {quo_q[29:0], 1'b1};
      end else begin
        rem_d = r2;
        quo_n = {quo_q[29:0], 1'b0};
      end
      quo_d = quo_n;
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'(gqa_pkg::DIV_STEPS - 1)) begin
        result_d = ({1'b0, quo_n} > 32'(gqa_pkg::ONE_Q30)) ? 32'(gqa_pkg::ONE_Q30)
                                                           : {1'b0, quo_n};
        done_d   = 1'b1;
        busy_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= gqa_pkg::OP_SQRT;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q      <= v_d;
    res_q    <= res_d;
    bit_q    <= bit_d;
    rem_q    <= rem_d;
    den_q    <= den_d;
    num_q    <= num_d;
    quo_q    <= quo_d;
    result_q <= result_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = result_q;

endmodule

@@ hw/rtl/gyro_quaternion_attitude_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_quaternion_attitude_top
// Euler-step quaternion integration of gyro rates with renormalization and
// CORDIC pitch/roll extraction.
// ----------------------------------------------------------------------------
// Datapath: one shared 33x33 multiplier, a bit-serial root/divide unit and a
// CORDIC running CORDIC_STEPS iterations twice. Saturated divides exit early and
// a zero magnitude skips the divides. Input is not ready while a word is in work.
// Reset: attitude goes to identity, time_step to 167772, channels idle.
// ----------------------------------------------------------------------------
module gyro_quaternion_attitude_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  gqa_in_if.sink      rate_i,
  gqa_out_if.source   att_o
);

  gqa_pkg::state_e    state_q, state_d;
  logic [4:0]         cnt_q, cnt_d;
  logic [1:0]         kidx_q, kidx_d;
  logic               pphase_q, pphase_d;
  logic               out_valid_q, out_valid_d;
  logic [23:0]        ts_q;
  logic signed [31:0] att_q [4];
  logic signed [31:0] att_d [4];
  logic signed [31:0] rate_q [3];
  logic signed [31:0] rate_d [3];
  logic signed [31:0] qn_q [4];
  logic signed [31:0] qn_d [4];
  logic signed [39:0] dsum_q [4];
  logic signed [39:0] dsum_d [4];
  logic signed [63:0] acc_q, acc_d;
  logic signed [65:0] mul_q;
  logic signed [32:0] mul_a, mul_b;
  logic [31:0]        mag_q, mag_d;
  logic signed [31:0] s_q, s_d;
  logic signed [36:0] cx_q, cx_d, cy_q, cy_d;
  logic signed [31:0] cz_q, cz_d;
  logic signed [30:0] pitch_q, pitch_d, roll_q, roll_d;

  gqa_pkg::unit_req_t ureq;
  gqa_pkg::unit_rsp_t ursp;
  logic [63:0]        uopa;
  logic [31:0]        uopb;

  gqa_pkg::term_t     tm_iss, tm_acc;
  logic [3:0]         t_acc;
  logic signed [63:0] term_v, base_v, sum_v;
  logic [1:0]         ek, eph;
  logic signed [39:0] sv;
  logic signed [63:0] prod_v;
  logic signed [38:0] delta_v;
  logic signed [40:0] qsum_v;
  logic signed [32:0] qext;
  logic [31:0]        qabs;
  logic signed [63:0] wide_v;
  logic signed [36:0] xs, ys;
  logic signed [31:0] at_v;
  logic               fin;
  logic signed [30:0] angle_v;
  logic               cfg_we;

  gqa_root_div u_root_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ureq),
    .opa_i  (uopa),
    .opb_i  (uopb),
    .rsp_o  (ursp)
  );

  assign cfg_we = psel & penable & pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == gqa_pkg::REG_TIME_STEP) ? {8'b0, ts_q} : 32'b0;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    kidx_d      = kidx_q;
    pphase_d    = pphase_q;
    out_valid_d = out_valid_q;
    att_d       = att_q;
    rate_d      = rate_q;
    qn_d        = qn_q;
    dsum_d      = dsum_q;
    acc_d       = acc_q;
    mag_d       = mag_q;
    s_d         = s_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    cz_d        = cz_q;
    pitch_d     = pitch_q;
    roll_d      = roll_q;
    mul_a       = '0;
    mul_b       = '0;
    ureq        = '{start: 1'b0, op: gqa_pkg::OP_SQRT};
    uopa        = '0;
    uopb        = '0;
    rate_i.ready = 1'b0;
    tm_iss      = '0;
    tm_acc      = '0;
    t_acc       = '0;
    term_v      = '0;
    base_v      = '0;
    sum_v       = '0;
    ek          = cnt_q[3:2];
    eph         = cnt_q[1:0];
    sv          = dsum_q[cnt_q[3:2]];
    prod_v      = '0;
    delta_v     = '0;
    qsum_v      = '0;
    qext        = 33'(qn_q[kidx_q]);
    qabs        = qext[32] ? 32'(-qext) : qext[31:0];
    wide_v      = '0;
    xs          = cx_q >>> cnt_q;
    ys          = cy_q >>> cnt_q;
    at_v        = gqa_pkg::atan_entry(cnt_q);
    fin         = 1'b0;
    angle_v     = '0;

    case (state_q)
      gqa_pkg::ST_IDLE: begin
        rate_i.ready = 1'b1;
        if (rate_i.valid) begin
          rate_d[0] = rate_i.rate_x;
          rate_d[1] = rate_i.rate_y;
          rate_d[2] = rate_i.rate_z;
          cnt_d     = '0;
          state_d   = gqa_pkg::ST_RATE;
        end
      end
      gqa_pkg::ST_RATE: begin
        tm_iss = gqa_pkg::rate_term(cnt_q[3:0]);
        mul_a  = 33'(att_q[tm_iss.qi]);
        mul_b  = 33'(rate_q[tm_iss.ri]);
        if (cnt_q != 5'd0) begin
          t_acc  = cnt_q[3:0] - 4'd1;
          tm_acc = gqa_pkg::rate_term(t_acc);
          term_v = 64'(mul_q >>> 16);
          if (tm_acc.neg) begin
            term_v = -term_v;
          end
          base_v = (tm_acc.pos == 2'd0) ? 64'sd0 : acc_q;
          sum_v  = base_v + term_v;
          acc_d  = sum_v;
          if (tm_acc.pos == 2'd2) begin
            dsum_d[tm_acc.comp] = gqa_pkg::sat40(sum_v);
          end
        end
        if (cnt_q == 5'd12) begin
          cnt_d   = '0;
          state_d = gqa_pkg::ST_EULER;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      gqa_pkg::ST_EULER: begin
        mul_b = {9'b0, ts_q};
        case (eph)
          2'd0: mul_a = 33'(sv >>> 20);
          2'd1: begin
            mul_a = {13'b0, sv[19:0]};
            acc_d = 64'(mul_q);
          end
          2'd2: begin
            prod_v     = (acc_q <<< 20) + 64'(mul_q);
            delta_v    = 39'(prod_v >>> 25);
            qsum_v     = 41'(att_q[ek]) + 41'(delta_v);
            qn_d[ek]   = gqa_pkg::sat32(qsum_v);
          end
          default: ;
        endcase
        if (eph == 2'd2) begin
          if (ek == 2'd3) begin
            cnt_d   = '0;
            state_d = gqa_pkg::ST_SQUARE;
          end else begin
            cnt_d = cnt_q + 5'd2;
          end
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      gqa_pkg::ST_SQUARE: begin
        mul_a = 33'(qn_q[cnt_q[1:0]]);
        mul_b = 33'(qn_q[cnt_q[1:0]]);
        if (cnt_q != 5'd0) begin
          base_v = (cnt_q == 5'd1) ? 64'sd0 : acc_q;
          acc_d  = base_v + 64'(mul_q >>> 2);
        end
        if (cnt_q == 5'd4) begin
          cnt_d   = '0;
          state_d = gqa_pkg::ST_MAG;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      gqa_pkg::ST_MAG: begin
        if (cnt_q == 5'd0) begin
          ureq  = '{start: 1'b1, op: gqa_pkg::OP_SQRT};
          uopa  = acc_q;
          cnt_d = 5'd1;
        end else if (ursp.done) begin
          mag_d = ursp.result;
          cnt_d = '0;
          if (ursp.result == 32'd0) begin
            qn_d[0] = gqa_pkg::ONE_Q30;
            qn_d[1] = '0;
            qn_d[2] = '0;
            qn_d[3] = '0;
            state_d = gqa_pkg::ST_PITCH;
          end else begin
            kidx_d  = '0;
            state_d = gqa_pkg::ST_DIV;
          end
        end
      end
      gqa_pkg::ST_DIV: begin
        if (cnt_q == 5'd0) begin
          ureq  = '{start: 1'b1, op: gqa_pkg::OP_DIV};
          uopa  = {3'b0, qabs, 29'b0};
          uopb  = mag_q;
          cnt_d = 5'd1;
        end else if (ursp.done) begin
          qn_d[kidx_q] = qext[32] ? -$signed(ursp.result) : $signed(ursp.result);
          cnt_d        = '0;
          if (kidx_q == 2'd3) begin
            state_d = gqa_pkg::ST_PITCH;
          end else begin
            kidx_d = kidx_q + 2'd1;
          end
        end
      end
      gqa_pkg::ST_PITCH: begin
        cnt_d = cnt_q + 5'd1;
        case (cnt_q)
          5'd0: begin
            mul_a = 33'(qn_q[0]);
            mul_b = 33'(qn_q[2]);
            att_d = qn_q;
          end
          5'd1: begin
            mul_a = 33'(qn_q[1]);
            mul_b = 33'(qn_q[3]);
            acc_d = 64'(mul_q);
          end
          5'd2: begin
            wide_v = (acc_q - 64'(mul_q)) >>> 29;
            if (wide_v > 64'(gqa_pkg::ONE_Q30)) begin
              s_d = gqa_pkg::ONE_Q30;
            end else if (wide_v < -64'(gqa_pkg::ONE_Q30)) begin
              s_d = -gqa_pkg::ONE_Q30;
            end else begin
              s_d = 32'(wide_v);
            end
          end
          5'd3: begin
            mul_a = 33'(s_q);
            mul_b = 33'(s_q);
          end
          5'd4: begin
            ureq    = '{start: 1'b1, op: gqa_pkg::OP_SQRT};
            uopa    = (64'd1 << 60) - 64'(mul_q);
            state_d = gqa_pkg::ST_PSQRT;
          end
          default: ;
        endcase
      end
      gqa_pkg::ST_PSQRT: begin
        if (ursp.done) begin
          cx_d     = $signed({5'b0, ursp.result});
          cy_d     = 37'(s_q);
          pphase_d = 1'b1;
          state_d  = gqa_pkg::ST_CINIT;
        end
      end
      gqa_pkg::ST_CINIT: begin
        cz_d  = '0;
        cnt_d = '0;
        if (cx_q == 37'sd0 && cy_q == 37'sd0) begin
          fin = 1'b1;
        end else begin
          if (cx_q[36]) begin
            if (!cy_q[36]) begin
              cx_d = cy_q;
              cy_d = -cx_q;
              cz_d = gqa_pkg::HALF_PI_Q28;
            end else begin
              cx_d = -cy_q;
              cy_d = cx_q;
              cz_d = -gqa_pkg::HALF_PI_Q28;
            end
          end
          state_d = gqa_pkg::ST_CORDIC;
        end
      end
      gqa_pkg::ST_CORDIC: begin
        if (cy_q > 37'sd0) begin
          cx_d = cx_q + ys;
          cy_d = cy_q - xs;
          cz_d = cz_q + at_v;
        end else begin
          cx_d = cx_q - ys;
          cy_d = cy_q + xs;
          cz_d = cz_q - at_v;
        end
        if (cnt_q == 5'(gqa_pkg::CORDIC_STEPS - 1)) begin
          fin = 1'b1;
          if (cz_d > gqa_pkg::PI_Q28) begin
            angle_v = 31'(gqa_pkg::PI_Q28);
          end else if (cz_d < -gqa_pkg::PI_Q28) begin
            angle_v = 31'(-gqa_pkg::PI_Q28);
          end else begin
            angle_v = 31'(cz_d);
          end
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      gqa_pkg::ST_ROLL: begin
        cnt_d = cnt_q + 5'd1;
        case (cnt_q)
          5'd0: begin
            mul_a = 33'(qn_q[2]);
            mul_b = 33'(qn_q[3]);
          end
          5'd1: begin
            mul_a = 33'(qn_q[0]);
            mul_b = 33'(qn_q[1]);
            acc_d = 64'(mul_q);
          end
          5'd2: begin
            mul_a  = 33'(qn_q[1]);
            mul_b  = 33'(qn_q[1]);
            wide_v = (acc_q + 64'(mul_q)) >>> 29;
            cy_d   = 37'(wide_v);
          end
          5'd3: begin
            mul_a = 33'(qn_q[2]);
            mul_b = 33'(qn_q[2]);
            acc_d = 64'(mul_q);
          end
          5'd4: begin
            wide_v   = 64'(gqa_pkg::ONE_Q30) - ((acc_q + 64'(mul_q)) >>> 29);
            cx_d     = 37'(wide_v);
            pphase_d = 1'b0;
            state_d  = gqa_pkg::ST_CINIT;
          end
          default: ;
        endcase
      end
      gqa_pkg::ST_OUT: begin
        if (att_o.ready) begin
          out_valid_d = 1'b0;
          state_d     = gqa_pkg::ST_IDLE;
        end
      end
      default: state_d = gqa_pkg::ST_IDLE;
    endcase

    if (fin) begin
      cnt_d = '0;
      if (pphase_q) begin
        pitch_d = angle_v;
        state_d = gqa_pkg::ST_ROLL;
      end else begin
        roll_d      = angle_v;
        out_valid_d = 1'b1;
        state_d     = gqa_pkg::ST_OUT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gqa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      kidx_q      <= '0;
      pphase_q    <= 1'b0;
      out_valid_q <= 1'b0;
      ts_q        <= gqa_pkg::TIME_STEP_RESET;
      att_q[0]    <= gqa_pkg::ONE_Q30;
      att_q[1]    <= '0;
      att_q[2]    <= '0;
      att_q[3]    <= '0;
    end else begin
      cnt_q       <= cnt_d;
      kidx_q      <= kidx_d;
      pphase_q    <= pphase_d;
      out_valid_q <= out_valid_d;
      att_q       <= att_d;
      if (cfg_we && paddr[2] == gqa_pkg::REG_TIME_STEP) begin
        ts_q <= pwdata[23:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rate_q  <= rate_d;
    qn_q    <= qn_d;
    dsum_q  <= dsum_d;
    acc_q   <= acc_d;
    mul_q   <= mul_a * mul_b;
    mag_q   <= mag_d;
    s_q     <= s_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    cz_q    <= cz_d;
    pitch_q <= pitch_d;
    roll_q  <= roll_d;
  end

  assign att_o.valid       = out_valid_q;
  assign att_o.att_w       = att_q[0];
  assign att_o.att_x       = att_q[1];
  assign att_o.att_y       = att_q[2];
  assign att_o.att_z       = att_q[3];
  assign att_o.pitch_angle = pitch_q;
  assign att_o.roll_angle  = roll_q;

endmodule
